FILE: rtl/lru_kv_pkg.sv
// Package for the LRU key-value cache: request and response transaction
// types and the command codes. No dependencies.
package lru_kv_pkg;

  localparam int CAP_BITS   = 5;
  localparam int KEY_FIELD  = 16;
  localparam int VAL_FIELD  = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [KEY_FIELD-1:0] lookup_key;
    logic [VAL_FIELD-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [VAL_FIELD-1:0] read_value;
    logic                 evicted;
  } rsp_t;

endpackage

FILE: rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lru_kv_pkg for the transaction types and command codes.
//
// Usage:
//   Input channel: drive in_req and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. busy is always low, so
//   one get or put is taken every cycle.
//   Result channel: out_valid is high for exactly one cycle with out_rsp
//   holding hit, read_value and evicted. There is no backpressure; the
//   receiver must take each result in the cycle it appears.
//   Configuration: cfg_we writes cfg_capacity; the user must do so only while the block is idle,
//   which the block itself does not enforce. A capacity of 0 acts as 1,
//   any value above ENTRIES acts as ENTRIES. A transaction passes one input
//   register and one result register before its result appears. Throughput
//   is one transaction per cycle, set by a single pass of parallel key
//   compares, a lowest-slot search and a rank update across all entries.
//   Reset (rst_n low, synchronous): all entries invalid, ranks and
//   occupancy zero, capacity 16. Keys and values need no clearing since
//   they are read only while their entry is valid.
module lru_key_value_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lru_kv_pkg::req_t                  in_req,
  output logic                              out_valid,
  output lru_kv_pkg::rsp_t                  out_rsp,
  input  logic                              cfg_we,
  input  logic [lru_kv_pkg::CAP_BITS-1:0]   cfg_capacity
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = 8;

  // Input register and configuration.
  logic                              in_valid_r;
  lru_kv_pkg::req_t                  in_r;
  logic [lru_kv_pkg::CAP_BITS-1:0]   cap_r;

  // Entry storage.
  logic [ENTRIES-1:0]                valid_r, valid_nxt;
  logic [KEY_BITS-1:0]               key_r   [ENTRIES];
  logic [VALUE_BITS-1:0]             val_r   [ENTRIES];
  logic [RANK_W-1:0]                 rank_r  [ENTRIES];
  logic [RANK_W-1:0]                 rank_nxt[ENTRIES];
  logic [OCC_W-1:0]                  occ_r, occ_nxt;

  // Result register.
  logic                              out_valid_r;
  lru_kv_pkg::rsp_t                  out_rsp_r, out_rsp_nxt;

  // Lookup datapath.
  logic [31:0]                       key_ext;
  logic [31:0]                       val_ext;
  logic [31:0]                       rd_ext;
  logic [KEY_BITS-1:0]               key_in;
  logic [VALUE_BITS-1:0]             val_in;
  logic                              is_put;
  logic                              hit_any;
  logic [IDX_W-1:0]                  hit_idx;
  logic                              free_any;
  logic [IDX_W-1:0]                  free_idx;
  logic [IDX_W-1:0]                  vic_idx;
  logic [RANK_W-1:0]                 rank_hit;
  logic [RANK_W-1:0]                 oldest_rank;
  logic [CMP_W-1:0]                  eff_cap;
  logic                              ins_fill;
  logic                              ins_any;
  logic [IDX_W-1:0]                  ins_slot;

  assign busy = 1'b0;

  assign key_ext = 32'(in_r.lookup_key);
  assign val_ext = 32'(in_r.write_value);
  assign key_in  = key_ext[KEY_BITS-1:0];
  assign val_in  = val_ext[VALUE_BITS-1:0];
  assign is_put  = (in_r.cmd == lru_kv_pkg::CMD_PUT);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  // Among valid entries the ranks are a permutation of 0 .. occupancy-1, so
  // the least recent entry is the one whose rank equals occupancy-1.
  assign oldest_rank = RANK_W'(occ_r - OCC_W'(1));

  // Parallel compares; scanning downward leaves the lowest-numbered match.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    vic_idx  = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (valid_r[j] && key_r[j] == key_in) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(j);
      end
      if (!valid_r[j]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(j);
      end
      if (valid_r[j] && rank_r[j] == oldest_rank) begin
        vic_idx = IDX_W'(j);
      end
    end
  end

  assign rank_hit = rank_r[hit_idx];
  assign ins_any  = is_put && !hit_any;
  assign ins_fill = ins_any && free_any && (CMP_W'(occ_r) < eff_cap);
  assign ins_slot = ins_fill ? free_idx : vic_idx;
  assign rd_ext   = 32'(val_r[hit_idx]);

  always_comb begin
    out_rsp_nxt.hit        = hit_any;
    out_rsp_nxt.read_value = (hit_any && !is_put) ? rd_ext[lru_kv_pkg::VAL_FIELD-1:0] : '0;
    out_rsp_nxt.evicted    = ins_any && !ins_fill;
  end

  // Recency update: the touched entry becomes rank 0 and every valid entry
  // that was more recent than it ages by one.
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int j = 0; j < ENTRIES; j++) begin
      rank_nxt[j] = rank_r[j];
    end
    if (in_valid_r) begin
      if (hit_any) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (IDX_W'(j) == hit_idx) begin
            rank_nxt[j] = '0;
          end else if (valid_r[j] && rank_r[j] < rank_hit) begin
            rank_nxt[j] = rank_r[j] + RANK_W'(1);
          end
        end
      end else if (ins_any) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (IDX_W'(j) == ins_slot) begin
            rank_nxt[j] = '0;
          end else if (valid_r[j]) begin
            rank_nxt[j] = rank_r[j] + RANK_W'(1);
          end
        end
        if (ins_fill) begin
          valid_nxt[ins_slot] = 1'b1;
          occ_nxt             = occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= lru_kv_pkg::CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_req;
    end
    if (in_valid_r) begin
      out_rsp_r <= out_rsp_nxt;
      if (hit_any && is_put) begin
        val_r[hit_idx] <= val_in;
      end else if (ins_any) begin
        key_r[ins_slot] <= key_in;
        val_r[ins_slot] <= val_in;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match the number of valid entries");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.evicted |-> !out_rsp_r.hit)
    else $error("eviction reported together with a hit");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && ins_any && !ins_fill |=> $stable(occ_r))
    else $error("eviction changed the occupancy");

  a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ins_fill |-> (CMP_W'(occ_r) < CMP_W'(ENTRIES)))
    else $error("fill attempted with all entries in use");
`endif

endmodule
